[design/nbc_pkg.sv]
`default_nettype none

package nbc_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    // bus widths
    localparam int SYMBOL_W = 8;
    localparam int M_DATA_W = 8;

    // bracket characters
    localparam logic [SYMBOL_W-1:0] CH_OPEN_CURLY  = 8'h7B;
    localparam logic [SYMBOL_W-1:0] CH_OPEN_ROUND  = 8'h28;
    localparam logic [SYMBOL_W-1:0] CH_CLOSE_ROUND = 8'h29;
    localparam logic [SYMBOL_W-1:0] CH_CLOSE_CURLY = 8'h7D;

    // stack entry kinds
    localparam logic KIND_ROUND = 1'b0;
    localparam logic KIND_CURLY = 1'b1;

    typedef struct packed {
        logic overflow;
        logic balanced;
    } result_t;

endpackage

`default_nettype wire

[design/nbc_ram.sv]
`default_nettype none

module nbc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/nbc_stack_ctrl.sv]
`default_nettype none

module nbc_stack_ctrl (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_acc,
    input  wire logic [nbc_pkg::SYMBOL_W-1:0]    symbol,
    input  wire logic                            has_symbol,
    input  wire logic                            last,
    output logic                                 res_valid,
    output nbc_pkg::result_t                     res
);

    // top of stack lives in top_reg or in the ram read register,
    // entries below it live in the ram
    logic [nbc_pkg::DEPTH_W-1:0] depth_reg, depth_next, depth_upd;
    logic                        failed_reg, failed_next, failed_upd;
    logic                        ovf_reg, ovf_next, ovf_upd;
    logic                        top_reg, top_next, top_upd;
    logic                        from_ram_reg, from_ram_next, from_ram_upd;

    logic                        top_kind;
    logic                        ram_rdata;
    logic                        do_push, do_pop;
    logic                        is_open, is_close, want_kind;
    logic [nbc_pkg::DEPTH_W-1:0] depth_m1, depth_m2;

    assign top_kind = from_ram_reg ? ram_rdata : top_reg;
    assign depth_m1 = depth_reg - nbc_pkg::DEPTH_W'(1);
    assign depth_m2 = depth_reg - nbc_pkg::DEPTH_W'(2);

    assign is_open   = (symbol == nbc_pkg::CH_OPEN_ROUND) || (symbol == nbc_pkg::CH_OPEN_CURLY);
    assign is_close  = (symbol == nbc_pkg::CH_CLOSE_ROUND) || (symbol == nbc_pkg::CH_CLOSE_CURLY);
    assign want_kind = (symbol == nbc_pkg::CH_CLOSE_CURLY) ? nbc_pkg::KIND_CURLY
                                                           : nbc_pkg::KIND_ROUND;

    always_comb begin
        depth_upd    = depth_reg;
        failed_upd   = failed_reg;
        ovf_upd      = ovf_reg;
        top_upd      = top_reg;
        from_ram_upd = from_ram_reg;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        if (in_acc && has_symbol && !failed_reg) begin
            if (symbol == nbc_pkg::CH_OPEN_CURLY && depth_reg == '0) begin
                failed_upd = 1'b1;
            end else if (is_open) begin
                if (depth_reg == nbc_pkg::DEPTH_W'(nbc_pkg::STACK_DEPTH)) begin
                    failed_upd = 1'b1;
                    ovf_upd    = 1'b1;
                end else begin
                    do_push      = 1'b1;
                    depth_upd    = depth_reg + nbc_pkg::DEPTH_W'(1);
                    top_upd      = (symbol == nbc_pkg::CH_OPEN_CURLY) ? nbc_pkg::KIND_CURLY
                                                                      : nbc_pkg::KIND_ROUND;
                    from_ram_upd = 1'b0;
                end
            end else if (is_close) begin
                if (depth_reg == '0 || top_kind != want_kind) begin
                    failed_upd = 1'b1;
                end else begin
                    do_pop       = 1'b1;
                    depth_upd    = depth_m1;
                    from_ram_upd = 1'b1;
                end
            end
        end
    end

    // end of string clears everything but the stack contents
    always_comb begin
        if (in_acc && last) begin
            depth_next    = '0;
            failed_next   = 1'b0;
            ovf_next      = 1'b0;
            top_next      = top_upd;
            from_ram_next = 1'b0;
        end else begin
            depth_next    = depth_upd;
            failed_next   = failed_upd;
            ovf_next      = ovf_upd;
            top_next      = top_upd;
            from_ram_next = from_ram_upd;
        end
    end

    assign res_valid    = in_acc && last;
    assign res.balanced = !failed_upd && (depth_upd == '0);
    assign res.overflow = ovf_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg    <= '0;
            failed_reg   <= 1'b0;
            ovf_reg      <= 1'b0;
            from_ram_reg <= 1'b0;
        end else begin
            depth_reg    <= depth_next;
            failed_reg   <= failed_next;
            ovf_reg      <= ovf_next;
            from_ram_reg <= from_ram_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
    end

    // push spills the old top, pop prefetches the entry that becomes top
    nbc_ram #(
        .WIDTH(1),
        .DEPTH(nbc_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (do_push && depth_reg != '0),
        .waddr (depth_m1[nbc_pkg::ADDR_W-1:0]),
        .wdata (top_kind),
        .re    (do_pop),
        .raddr (depth_m2[nbc_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[design/nbc_out_buf.sv]
`default_nettype none

module nbc_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  nbc_pkg::result_t       push_res,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nbc_pkg::result_t       out_res
);

    logic             main_v_reg, main_v_next;
    logic             skid_v_reg, skid_v_next;
    nbc_pkg::result_t main_reg, main_next;
    nbc_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop = main_v_reg && out_ready;

    always_comb begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (pop) begin
            main_v_next = skid_v_reg;
            main_next   = skid_reg;
            skid_v_next = 1'b0;
        end
        if (push) begin
            if (!main_v_next) begin
                main_v_next = 1'b1;
                main_next   = push_res;
            end else begin
                skid_v_next = 1'b1;
                skid_next   = push_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_res   = main_reg;

endmodule

`default_nettype wire

[design/nested_bracket_checker_unit.sv]
`default_nettype none

// nested bracket checker: one character per input transaction on the s_ channel,
// with s_tdata carrying the character, s_tuser marking it as present and s_tlast
// closing the string. round and curly brackets must nest properly, a curly opening
// at depth zero fails, and failure sticks until the end of the string.
// the transaction with s_tlast yields one result transaction on the m_ channel:
// balanced in bit 0 and stack overflow in bit 1 of m_tdata.
// throughput is one character per cycle while s_tready is high, as each character
// does at most one push or pop on the stack ram; the top entry is held in a register
// and a pop prefetches the next one from the ram, so back-to-back pops never wait on
// the ram read. each result is registered in the output buffer ahead of m_tvalid.
// results wait in a two-entry output buffer; s_tready drops only while both entries
// are held, so a stalled receiver stops the input after two pending strings.
// reset clears the depth counter, the sticky flags and the output buffer; stack ram
// contents are left alone as an entry is only read after it was pushed in the string,
// so no clearing pass is needed and s_tready is high straight after reset

module nested_bracket_checker_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input character channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic        s_tuser,   // [0] has_symbol
    input  wire logic        s_tlast,   // last character of the string
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] balanced, [1] overflow, [7:2] zero
);

    logic             s_acc;
    logic             res_valid;
    nbc_pkg::result_t res;
    nbc_pkg::result_t out_res;
    logic             buf_full;

    // input transaction taken whenever the skid entry is free
    assign s_tready = !buf_full;
    assign s_acc    = s_tvalid && s_tready;

    // stack control with its ram
    nbc_stack_ctrl u_stack_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_acc     (s_acc),
        .symbol     (s_tdata),
        .has_symbol (s_tuser),
        .last       (s_tlast),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register plus skid entry
    nbc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_res  (res),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {(nbc_pkg::M_DATA_W - 2)'(0), out_res.overflow, out_res.balanced};

    // skid entry only fills behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn) !s_tready |-> m_tvalid)
        else $error("output buffer skid entry full without a pending result");

    // a string end always leaves a result valid next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no result after last character");

    // overflow never reported as balanced
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
        else $error("overflow reported together with balanced");

    // without a string end no new result may appear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !(s_tvalid && s_tready && s_tlast)) |=> !m_tvalid)
        else $error("result appeared without a last character");

endmodule

`default_nettype wire

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nbc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                has_symbol;
        logic                last;
    } char_item_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    // shadow of the checker state
    logic               kind_stack [STACK_DEPTH];
    logic [DEPTH_W-1:0] shadow_depth;
    logic               shadow_failed;
    logic               shadow_overflow;

    result_t    pending_verdicts [$];
    char_item_t queued_chars [$];
    int         chars_sent;
    int         verdicts_seen;
    int         verdict_mismatches;
    int         cycle_count;
    bit         burst_mode;

    nested_bracket_checker_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic bit is_bracket(input logic [SYMBOL_W-1:0] ch);
        return ch == CH_OPEN_ROUND || ch == CH_OPEN_CURLY ||
               ch == CH_CLOSE_ROUND || ch == CH_CLOSE_CURLY;
    endfunction

    function automatic logic [SYMBOL_W-1:0] random_text_byte();
        logic [SYMBOL_W-1:0] ch;
        ch = SYMBOL_W'($urandom_range(0, 255));
        while (is_bracket(ch))
            ch = SYMBOL_W'($urandom_range(0, 255));
        return ch;
    endfunction

    function automatic logic [SYMBOL_W-1:0] random_bracket_byte();
        case ($urandom_range(0, 3))
            0:       return CH_OPEN_ROUND;
            1:       return CH_OPEN_CURLY;
            2:       return CH_CLOSE_ROUND;
            default: return CH_CLOSE_CURLY;
        endcase
    endfunction

    function automatic char_item_t make_char(input logic [SYMBOL_W-1:0] ch, input logic has,
                                             input logic last);
        char_item_t c;
        c.symbol     = ch;
        c.has_symbol = has;
        c.last       = last;
        return c;
    endfunction

    task automatic add_char(input logic [SYMBOL_W-1:0] ch, input logic has, input logic last);
        queued_chars.push_back(make_char(ch, has, last));
    endtask

    // advance the shadow nesting state by one character, queue a verdict on the last one
    task automatic track_nesting(input char_item_t c);
        result_t            verdict;
        logic               want;
        logic [DEPTH_W-1:0] below;
        if (c.has_symbol && !shadow_failed) begin
            if (c.symbol == CH_OPEN_CURLY && shadow_depth == 0) begin
                shadow_failed = 1'b1;
            end else if (c.symbol == CH_OPEN_ROUND || c.symbol == CH_OPEN_CURLY) begin
                if (shadow_depth >= STACK_DEPTH) begin
                    shadow_failed   = 1'b1;
                    shadow_overflow = 1'b1;
                end else begin
                    kind_stack[shadow_depth[ADDR_W-1:0]] =
                        (c.symbol == CH_OPEN_CURLY) ? KIND_CURLY : KIND_ROUND;
                    shadow_depth = shadow_depth + 1'b1;
                end
            end else if (c.symbol == CH_CLOSE_ROUND || c.symbol == CH_CLOSE_CURLY) begin
                want  = (c.symbol == CH_CLOSE_CURLY) ? KIND_CURLY : KIND_ROUND;
                below = shadow_depth - 1'b1;
                if (shadow_depth == 0 || shadow_depth > STACK_DEPTH)
                    shadow_failed = 1'b1;
                else if (kind_stack[below[ADDR_W-1:0]] != want)
                    shadow_failed = 1'b1;
                else
                    shadow_depth = shadow_depth - 1'b1;
            end
        end
        if (c.last) begin
            verdict.balanced = !shadow_failed && shadow_depth == 0;
            verdict.overflow = shadow_overflow;
            pending_verdicts.push_back(verdict);
            shadow_depth    = '0;
            shadow_failed   = 1'b0;
            shadow_overflow = 1'b0;
        end
    endtask

    // one input transaction; s_tvalid stays high afterwards
    task automatic send_char(input char_item_t c);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c.symbol;
        s_tuser  <= c.has_symbol;
        s_tlast  <= c.last;
        do @(posedge aclk); while (!s_tready);
        track_nesting(c);
        chars_sent++;
    endtask

    task automatic send_string();
        while (queued_chars.size() != 0)
            send_char(queued_chars.pop_front());
    endtask

    // mostly balanced text with random content, optionally broken in one place
    task automatic build_nested_string(input int max_len, input int open_w,
                                       input bit allow_break);
        logic       open_kinds [$];
        char_item_t c;
        int         len;
        int         sel;
        logic       k;
        len = $urandom_range(0, max_len);
        for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < open_w && open_kinds.size() < STACK_DEPTH + 4) begin
                k = (open_kinds.size() == 0) ? KIND_ROUND : logic'($urandom_range(0, 1));
                open_kinds.push_back(k);
                add_char(k == KIND_CURLY ? CH_OPEN_CURLY : CH_OPEN_ROUND, 1'b1, 1'b0);
            end else if (sel >= open_w && sel < open_w + 3 && open_kinds.size() != 0) begin
                k = open_kinds.pop_back();
                add_char(k == KIND_CURLY ? CH_CLOSE_CURLY : CH_CLOSE_ROUND, 1'b1, 1'b0);
            end else if (sel == 9) begin
                add_char(SYMBOL_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else begin
                add_char(random_text_byte(), 1'b1, 1'b0);
            end
        end
        while (open_kinds.size() != 0) begin
            k = open_kinds.pop_back();
            add_char(k == KIND_CURLY ? CH_CLOSE_CURLY : CH_CLOSE_ROUND, 1'b1, 1'b0);
        end
        if (allow_break && $urandom_range(0, 3) == 0) begin
            if (queued_chars.size() != 0 && $urandom_range(0, 1) == 1)
                queued_chars.delete($urandom_range(0, queued_chars.size() - 1));
            else
                queued_chars.insert($urandom_range(0, queued_chars.size()),
                                    make_char(random_bracket_byte(), 1'b1, 1'b0));
        end
        if (queued_chars.size() != 0 && $urandom_range(0, 1) == 1) begin
            c = queued_chars.pop_back();
            c.last = 1'b1;
            queued_chars.push_back(c);
        end else begin
            add_char(SYMBOL_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic test_directed_cases();
        add_char(8'h00, 1'b0, 1'b1);                  // empty string
        send_string();
        add_char(CH_OPEN_ROUND, 1'b1, 1'b0);          // simple pair, last on the close
        add_char(CH_CLOSE_ROUND, 1'b1, 1'b1);
        send_string();
        add_char(CH_OPEN_CURLY, 1'b1, 1'b0);          // curly opening at depth zero
        add_char(CH_CLOSE_CURLY, 1'b1, 1'b1);
        send_string();
        add_char(CH_CLOSE_ROUND, 1'b1, 1'b1);         // close on an empty stack
        send_string();
        add_char(CH_OPEN_ROUND, 1'b1, 1'b0);          // wrong kind of close
        add_char(CH_CLOSE_CURLY, 1'b1, 1'b1);
        send_string();
        add_char(CH_OPEN_ROUND, 1'b1, 1'b0);          // nested curly, extreme bytes, hidden open
        add_char(8'h00, 1'b1, 1'b0);
        add_char(CH_OPEN_CURLY, 1'b1, 1'b0);
        add_char(8'hFF, 1'b1, 1'b0);
        add_char(CH_CLOSE_CURLY, 1'b1, 1'b0);
        add_char(CH_OPEN_ROUND, 1'b0, 1'b0);
        add_char(CH_CLOSE_ROUND, 1'b1, 1'b1);
        send_string();
        add_char(CH_OPEN_ROUND, 1'b1, 1'b0);          // left open at the end
        add_char(8'hFF, 1'b0, 1'b1);
        send_string();
        add_char(CH_CLOSE_CURLY, 1'b1, 1'b0);         // failure stays sticky
        add_char(CH_OPEN_ROUND, 1'b1, 1'b0);
        add_char(CH_CLOSE_ROUND, 1'b1, 1'b1);
        send_string();
    endtask

    task automatic test_stack_limits();
        // exactly full, then emptied again
        add_char(CH_OPEN_ROUND, 1'b1, 1'b0);
        for (int i = 1; i < STACK_DEPTH; i++)
            add_char(CH_OPEN_CURLY, 1'b1, 1'b0);
        for (int i = 1; i < STACK_DEPTH; i++)
            add_char(CH_CLOSE_CURLY, 1'b1, 1'b0);
        add_char(CH_CLOSE_ROUND, 1'b1, 1'b1);
        send_string();
        // one opening past full, then the closes
        for (int i = 0; i <= STACK_DEPTH; i++)
            add_char(CH_OPEN_ROUND, 1'b1, 1'b0);
        for (int i = 0; i <= STACK_DEPTH; i++)
            add_char(CH_CLOSE_ROUND, 1'b1, 1'b0);
        add_char(8'h00, 1'b0, 1'b1);
        send_string();
        // overflow that follows an earlier failure is not reported
        add_char(CH_CLOSE_ROUND, 1'b1, 1'b0);
        for (int i = 0; i <= STACK_DEPTH; i++)
            add_char(CH_OPEN_ROUND, 1'b1, 1'b0);
        add_char(CH_OPEN_ROUND, 1'b1, 1'b1);
        send_string();
    endtask

    task automatic test_random_strings(input int target);
        int start;
        start = chars_sent;
        while (chars_sent - start < target) begin
            if ($urandom_range(0, 39) == 0)
                build_nested_string(200, 7, 1'b1);
            else
                build_nested_string(24, 4, 1'b1);
            send_string();
        end
    endtask

    task automatic test_noise(input int target);
        int start;
        start = chars_sent;
        while (chars_sent - start < target) begin
            add_char($urandom_range(0, 1) ? random_bracket_byte()
                                          : SYMBOL_W'($urandom_range(0, 255)),
                     $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
            send_string();
        end
        add_char(SYMBOL_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_string();
    endtask

    task automatic test_back_to_back(input int target);
        burst_mode = 1'b1;
        test_random_strings(target);
        burst_mode = 1'b0;
    endtask

    // hold the input until every verdict has come back
    task automatic test_drain_pause();
        for (int round = 0; round < 4; round++) begin
            repeat ($urandom_range(1, 5)) begin
                build_nested_string(12, 4, 1'b1);
                send_string();
            end
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (pending_verdicts.size() != 0);
        end
    endtask

    // result receiver with random stalls
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare every result transaction against the oldest expected verdict
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[1:0]);
            if (pending_verdicts.size() == 0) begin
                verdict_mismatches++;
                if (verdict_mismatches <= 10)
                    $display("verdict %0d unexpected: m_tdata=%b", verdicts_seen, m_tdata);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.balanced !== want.balanced || got.overflow !== want.overflow ||
                    m_tdata[7:2] !== '0) begin
                    verdict_mismatches++;
                    if (verdict_mismatches <= 10)
                        $display("verdict %0d: expected balanced=%b overflow=%b, got %b",
                                 verdicts_seen, want.balanced, want.overflow, m_tdata);
                end
            end
            verdicts_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn         <= 1'b0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tuser         <= 1'b0;
        s_tlast         <= 1'b0;
        shadow_depth    = '0;
        shadow_failed   = 1'b0;
        shadow_overflow = 1'b0;
        burst_mode      = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_stack_limits();
        test_random_strings(950);
        test_noise(350);
        test_back_to_back(200);
        test_drain_pause();

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_verdicts.size() != 0);
        repeat (8) @(posedge aclk);
        if (verdict_mismatches == 0 && pending_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
